@@ design/assert_macros.svh @@
// Assertion macros for the converter RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication under reset
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/sjk_pkg.sv @@
// Types and constants for the Shift-JIS / ku-ten converter.
// Depends on nothing; used by the decoder, encoder and top level.
package sjk_pkg;

    localparam logic [1:0] OP_SJIS_TO_KUTEN = 2'd0;
    localparam logic [1:0] OP_KUTEN_TO_SJIS = 2'd1;
    localparam logic [1:0] OP_KUTEN_TO_JIS  = 2'd2;
    localparam logic [1:0] OP_JIS_TO_KUTEN  = 2'd3;

    localparam logic [7:0] JIS_OFFSET = 8'h20;

    localparam logic [9:0] LOW_LEAD_BASE  = 10'd257;
    localparam logic [9:0] HIGH_LEAD_BASE = 10'd385;
    localparam logic [7:0] EVEN_TEN_BASE  = 8'd158;
    localparam logic [7:0] LOW_ROW_LAST   = 8'd62;

    localparam logic [7:0] LEAD_LO_FIRST = 8'h81;
    localparam logic [7:0] LEAD_LO_LAST  = 8'h9F;
    localparam logic [7:0] LEAD_HI_FIRST = 8'hE0;
    localparam logic [7:0] LEAD_HI_LAST  = 8'hEF;
    localparam logic [7:0] TRAIL_ODD_A_FIRST = 8'h40;
    localparam logic [7:0] TRAIL_ODD_A_LAST  = 8'h7E;
    localparam logic [7:0] TRAIL_ODD_B_FIRST = 8'h80;
    localparam logic [7:0] TRAIL_ODD_B_LAST  = 8'h9E;
    localparam logic [7:0] TRAIL_EVEN_FIRST  = 8'h9F;
    localparam logic [7:0] TRAIL_EVEN_LAST   = 8'hFC;
    localparam logic [7:0] ASCII_FIRST = 8'h20;
    localparam logic [7:0] ASCII_LAST  = 8'h7E;
    localparam logic [7:0] KANA_FIRST  = 8'hA1;
    localparam logic [7:0] KANA_LAST   = 8'hDF;
    localparam logic [6:0] NONSTD_FIRST = 7'd9;
    localparam logic [6:0] NONSTD_LAST  = 7'd15;

    typedef struct packed {
        logic [7:0] ku;
        logic [7:0] ten;
        logic       regular;
        logic       nonstd;
    } dec_result_t;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] trail;
    } enc_result_t;

endpackage

@@ design/sjk_decode.sv @@
// Shift-JIS byte pair to ku/ten decoder with regularity and row flags.
// Depends on sjk_pkg.
module sjk_decode
(
    input  logic [7:0]          lead,
    input  logic [7:0]          trail,
    output sjk_pkg::dec_result_t result
);

    logic       lead_low;
    logic       lead_high;
    logic       upper;
    logic [9:0] lead_x2;
    logic [9:0] row_wide;
    logic [6:0] row;
    logic       trail_odd_a;
    logic       trail_odd_b;
    logic       trail_even;
    logic [7:0] ten_val;
    logic       single_ok;

    assign lead_low  = (lead >= sjk_pkg::LEAD_LO_FIRST) && (lead <= sjk_pkg::LEAD_LO_LAST);
    assign lead_high = (lead >= sjk_pkg::LEAD_HI_FIRST) && (lead <= sjk_pkg::LEAD_HI_LAST);
    assign upper     = (trail > sjk_pkg::TRAIL_ODD_B_LAST);
    assign lead_x2   = {1'b0, lead, 1'b0};

    assign trail_odd_a = (trail >= sjk_pkg::TRAIL_ODD_A_FIRST) &&
                         (trail <= sjk_pkg::TRAIL_ODD_A_LAST);
    assign trail_odd_b = (trail >= sjk_pkg::TRAIL_ODD_B_FIRST) &&
                         (trail <= sjk_pkg::TRAIL_ODD_B_LAST);
    assign trail_even  = (trail >= sjk_pkg::TRAIL_EVEN_FIRST) &&
                         (trail <= sjk_pkg::TRAIL_EVEN_LAST);

    always_comb
    begin
        if (lead_low)
        begin
            row_wide = lead_x2 + {9'd0, upper} - sjk_pkg::LOW_LEAD_BASE;
        end
        else if (lead_high)
        begin
            row_wide = lead_x2 + {9'd0, upper} - sjk_pkg::HIGH_LEAD_BASE;
        end
        else
        begin
            row_wide = 10'd0;
        end
    end

    assign row = row_wide[6:0];

    always_comb
    begin
        if (row == 7'd0)
        begin
            ten_val = 8'd0;
        end
        else if (row[0] && trail_odd_a)
        begin
            ten_val = trail - 8'd63;
        end
        else if (row[0] && trail_odd_b)
        begin
            ten_val = trail - 8'd64;
        end
        else if (!row[0] && trail_even)
        begin
            ten_val = trail - sjk_pkg::EVEN_TEN_BASE;
        end
        else
        begin
            ten_val = 8'd0;
        end
    end

    assign single_ok = (trail == 8'd0) &&
        (((lead >= sjk_pkg::ASCII_FIRST) && (lead <= sjk_pkg::ASCII_LAST)) ||
         ((lead >= sjk_pkg::KANA_FIRST) && (lead <= sjk_pkg::KANA_LAST)));

    assign result.ku      = {1'b0, row};
    assign result.ten     = ten_val;
    assign result.regular = single_ok ||
        ((lead_low || lead_high) &&
         (row[0] ? (trail_odd_a || trail_odd_b) : trail_even));
    assign result.nonstd  = (row >= sjk_pkg::NONSTD_FIRST) && (row <= sjk_pkg::NONSTD_LAST);

endmodule

@@ design/sjk_encode.sv @@
// Ku/ten to Shift-JIS byte pair encoder, bytes wrap to eight bits.
// Depends on sjk_pkg.
module sjk_encode
(
    input  logic [7:0]           ku,
    input  logic [7:0]           ten,
    output sjk_pkg::enc_result_t result
);

    logic [9:0] lead_sum;
    logic [7:0] trail_val;

    always_comb
    begin
        if (ku <= sjk_pkg::LOW_ROW_LAST)
        begin
            lead_sum = {2'b00, ku} + sjk_pkg::LOW_LEAD_BASE;
        end
        else
        begin
            lead_sum = {2'b00, ku} + sjk_pkg::HIGH_LEAD_BASE;
        end
    end

    always_comb
    begin
        if (!ku[0])
        begin
            trail_val = ten + sjk_pkg::EVEN_TEN_BASE;
        end
        else if ((ten >= 8'd1) && (ten <= 8'd63))
        begin
            trail_val = ten + 8'd63;
        end
        else
        begin
            trail_val = ten + 8'd64;
        end
    end

    assign result.lead  = (ku == 8'd0) ? 8'd0 : lead_sum[8:1];
    assign result.trail = (ku == 8'd0) ? 8'd0 : trail_val;

endmodule

@@ design/sjis_kuten_code_converter.sv @@
// Top level of the Shift-JIS / ku-ten converter: input register, converters, result register.
// Depends on sjk_pkg, sjk_decode, sjk_encode and assert_macros.svh.
//
//  channel   handshake        payload
//  request   start / busy     opcode, first_byte, second_byte
//  result    done (strobe)    first_result, second_result, is_regular, is_nonstandard
//
// One request per cycle; busy stays low.
// A request passes through the input register, then the conversion logic into the result register.
// done is high for one cycle per request; the receiver cannot stall.
// Reset clears the valid bits of both registers; payload is not reset.
`include "assert_macros.svh"

module sjis_kuten_code_converter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] opcode,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    output logic       done,
    output logic [7:0] first_result,
    output logic [7:0] second_result,
    output logic       is_regular,
    output logic       is_nonstandard
);

    logic       in_valid_reg;
    logic [1:0] in_op_reg;
    logic [7:0] in_first_reg;
    logic [7:0] in_second_reg;

    logic       out_valid_reg;
    logic [7:0] out_first_reg;
    logic [7:0] out_second_reg;
    logic       out_regular_reg;
    logic       out_nonstd_reg;

    logic [7:0] out_first_next;
    logic [7:0] out_second_next;
    logic       out_regular_next;
    logic       out_nonstd_next;

    sjk_pkg::dec_result_t dec;
    sjk_pkg::enc_result_t enc;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_op_reg     <= opcode;
            in_first_reg  <= first_byte;
            in_second_reg <= second_byte;
        end
        if (in_valid_reg)
        begin
            out_first_reg   <= out_first_next;
            out_second_reg  <= out_second_next;
            out_regular_reg <= out_regular_next;
            out_nonstd_reg  <= out_nonstd_next;
        end
    end

    sjk_decode u_decode
    (
        .lead   (in_first_reg),
        .trail  (in_second_reg),
        .result (dec)
    );

    sjk_encode u_encode
    (
        .ku     (in_first_reg),
        .ten    (in_second_reg),
        .result (enc)
    );

    always_comb
    begin
        out_regular_next = 1'b0;
        out_nonstd_next  = 1'b0;
        unique case (in_op_reg)
            sjk_pkg::OP_SJIS_TO_KUTEN:
            begin
                out_first_next   = dec.ku;
                out_second_next  = dec.ten;
                out_regular_next = dec.regular;
                out_nonstd_next  = dec.nonstd;
            end
            sjk_pkg::OP_KUTEN_TO_SJIS:
            begin
                out_first_next  = enc.lead;
                out_second_next = enc.trail;
            end
            sjk_pkg::OP_KUTEN_TO_JIS:
            begin
                out_first_next  = in_first_reg + sjk_pkg::JIS_OFFSET;
                out_second_next = in_second_reg + sjk_pkg::JIS_OFFSET;
            end
            default:
            begin
                out_first_next  = in_first_reg - sjk_pkg::JIS_OFFSET;
                out_second_next = in_second_reg - sjk_pkg::JIS_OFFSET;
            end
        endcase
    end

    assign done           = out_valid_reg;
    assign first_result   = out_first_reg;
    assign second_result  = out_second_reg;
    assign is_regular     = out_regular_reg;
    assign is_nonstandard = out_nonstd_reg;

    `ASSERT_NEXT(a_accept_to_stage, clk, rst_n, start && !busy, in_valid_reg)
    `ASSERT_NEXT(a_stage_to_done, clk, rst_n, in_valid_reg, done)
    `ASSERT_NEXT(a_flags_only_decode, clk, rst_n,
        in_valid_reg && (in_op_reg != sjk_pkg::OP_SJIS_TO_KUTEN),
        !is_regular && !is_nonstandard)
    `ASSERT_IMPLY(a_nonstd_row, clk, rst_n, done && is_nonstandard,
        (first_result >= 8'd9) && (first_result <= 8'd15))

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for sjis_kuten_code_converter: a directed table of requests,
// then 650 random requests sent in bursts, each result checked in order.
// Depends on sjk_pkg and the sjis_kuten_code_converter top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 650;
    localparam int STALL_LIMIT     = 200;
    localparam int TAIL_CYCLES     = 4;
    localparam int DIRECTED_ROWS   = 25;

    typedef struct packed {
        logic [7:0] res_first;
        logic [7:0] res_second;
        logic       regular;
        logic       nonstd;
    } code_pair_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] arg_first;
        logic [7:0] arg_second;
        bit         pinned;
        code_pair_t value;
    } directed_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] opcode;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       done;
    logic [7:0] first_result;
    logic [7:0] second_result;
    logic       is_regular;
    logic       is_nonstandard;

    code_pair_t pending_codes[$];
    bit         pinned_valid;
    code_pair_t pinned_value;
    int         mismatch_count;
    int         quiet_cycles;
    int         burst_left;
    bit         progress;
    code_pair_t want;
    code_pair_t got;

    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h41, 8'h00, 1'b1, '{8'd0, 8'd0, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h7E, 8'h00, 1'b1, '{8'd0, 8'd0, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h7F, 8'h00, 1'b1, '{8'd0, 8'd0, 1'b0, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'hA1, 8'h00, 1'b1, '{8'd0, 8'd0, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'hDF, 8'h00, 1'b1, '{8'd0, 8'd0, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h81, 8'h40, 1'b1, '{8'd1, 8'd1, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h81, 8'h9E, 1'b1, '{8'd1, 8'd94, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h81, 8'h7F, 1'b1, '{8'd1, 8'd0, 1'b0, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h81, 8'hFD, 1'b1, '{8'd2, 8'd0, 1'b0, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h85, 8'h40, 1'b1, '{8'd9, 8'd1, 1'b1, 1'b1}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h88, 8'h40, 1'b1, '{8'd15, 8'd1, 1'b1, 1'b1}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h88, 8'h9F, 1'b1, '{8'd16, 8'd1, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'h9F, 8'hFC, 1'b1, '{8'd62, 8'd94, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'hE0, 8'h40, 1'b1, '{8'd63, 8'd1, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'hEF, 8'hFC, 1'b1, '{8'd94, 8'd94, 1'b1, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'hFF, 8'hFF, 1'b1, '{8'd0, 8'd0, 1'b0, 1'b0}},
        '{sjk_pkg::OP_SJIS_TO_KUTEN, 8'hA1, 8'h41, 1'b0, '0},
        '{sjk_pkg::OP_KUTEN_TO_SJIS, 8'd0, 8'h55, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0}},
        '{sjk_pkg::OP_KUTEN_TO_SJIS, 8'd1, 8'd1, 1'b1, '{8'h81, 8'h40, 1'b0, 1'b0}},
        '{sjk_pkg::OP_KUTEN_TO_SJIS, 8'd62, 8'd1, 1'b1, '{8'h9F, 8'h9F, 1'b0, 1'b0}},
        '{sjk_pkg::OP_KUTEN_TO_SJIS, 8'd63, 8'd63, 1'b1, '{8'hE0, 8'h7E, 1'b0, 1'b0}},
        '{sjk_pkg::OP_KUTEN_TO_SJIS, 8'd94, 8'd94, 1'b1, '{8'hEF, 8'hFC, 1'b0, 1'b0}},
        '{sjk_pkg::OP_KUTEN_TO_SJIS, 8'd255, 8'd255, 1'b1, '{8'h40, 8'h3F, 1'b0, 1'b0}},
        '{sjk_pkg::OP_KUTEN_TO_JIS, 8'hFF, 8'h00, 1'b1, '{8'h1F, 8'h20, 1'b0, 1'b0}},
        '{sjk_pkg::OP_JIS_TO_KUTEN, 8'h00, 8'hFF, 1'b1, '{8'hE0, 8'hDF, 1'b0, 1'b0}}
    };

    sjis_kuten_code_converter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .first_byte     (first_byte),
        .second_byte    (second_byte),
        .done           (done),
        .first_result   (first_result),
        .second_result  (second_result),
        .is_regular     (is_regular),
        .is_nonstandard (is_nonstandard)
    );

    function automatic code_pair_t convert_code(logic [1:0] op, logic [7:0] a, logic [7:0] b);
        code_pair_t  r;
        int unsigned lead;
        int unsigned trail;
        int unsigned ku;
        int unsigned ten;
        int unsigned upper;
        bit          double_lead;
        lead  = a;
        trail = b;
        r     = '0;
        case (op)
            sjk_pkg::OP_SJIS_TO_KUTEN:
            begin
                upper       = (trail > 32'h9E) ? 1 : 0;
                double_lead = (lead >= 32'h81 && lead <= 32'h9F) ||
                              (lead >= 32'hE0 && lead <= 32'hEF);
                if (lead >= 32'h81 && lead <= 32'h9F)
                    ku = upper + lead * 2 - 257;
                else if (lead >= 32'hE0 && lead <= 32'hEF)
                    ku = upper + lead * 2 - 385;
                else
                    ku = 0;
                if (ku == 0)
                    ten = 0;
                else if (ku[0] && trail >= 32'h40 && trail <= 32'h7E)
                    ten = trail - 63;
                else if (ku[0] && trail >= 32'h80 && trail <= 32'h9E)
                    ten = trail - 64;
                else if (!ku[0] && trail >= 32'h9F && trail <= 32'hFC)
                    ten = trail - 158;
                else
                    ten = 0;
                r.res_first  = ku[7:0];
                r.res_second = ten[7:0];
                if (trail == 0 && lead >= 32'h20 && lead <= 32'h7E)
                    r.regular = 1'b1;
                else if (trail == 0 && lead >= 32'hA1 && lead <= 32'hDF)
                    r.regular = 1'b1;
                else if (double_lead && ku[0])
                    r.regular = (trail >= 32'h40 && trail <= 32'h7E) ||
                                (trail >= 32'h80 && trail <= 32'h9E);
                else if (double_lead)
                    r.regular = trail >= 32'h9F && trail <= 32'hFC;
                r.nonstd = ku >= 9 && ku <= 15;
            end
            sjk_pkg::OP_KUTEN_TO_SJIS:
            begin
                if (lead != 0)
                begin
                    ku  = (lead <= 62) ? (lead + 257) / 2 : (lead + 385) / 2;
                    if (!lead[0])
                        ten = trail + 158;
                    else if (trail >= 1 && trail <= 63)
                        ten = trail + 63;
                    else
                        ten = trail + 64;
                    r.res_first  = ku[7:0];
                    r.res_second = ten[7:0];
                end
            end
            sjk_pkg::OP_KUTEN_TO_JIS:
            begin
                r.res_first  = a + sjk_pkg::JIS_OFFSET;
                r.res_second = b + sjk_pkg::JIS_OFFSET;
            end
            default:
            begin
                r.res_first  = a - sjk_pkg::JIS_OFFSET;
                r.res_second = b - sjk_pkg::JIS_OFFSET;
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(string what, code_pair_t expected, code_pair_t actual);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s expected %h %h reg=%b ns=%b, got %h %h reg=%b ns=%b", $realtime,
                     what, expected.res_first, expected.res_second, expected.regular,
                     expected.nonstd, actual.res_first, actual.res_second, actual.regular,
                     actual.nonstd);
    endtask

    task automatic send_request(logic [1:0] op, logic [7:0] a, logic [7:0] b,
                                bit pin, code_pair_t pin_value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                start = 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        start        = 1'b1;
        opcode       = op;
        first_byte   = a;
        second_byte  = b;
        pinned_valid = pin;
        pinned_value = pin_value;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_codes.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_random_request();
        logic [1:0] op;
        logic [7:0] a;
        logic [7:0] b;
        int         mode;
        op   = ($urandom_range(0, 1) == 0) ? sjk_pkg::OP_SJIS_TO_KUTEN
                                           : 2'($urandom_range(1, 3));
        a    = 8'($urandom);
        b    = 8'($urandom);
        mode = $urandom_range(0, 9);
        if (op == sjk_pkg::OP_SJIS_TO_KUTEN)
        begin
            if (mode <= 4)
            begin
                a = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h81, 8'h9F))
                                                : 8'($urandom_range(8'hE0, 8'hEF));
                if (mode <= 3)
                    b = 8'($urandom_range(8'h40, 8'hFC));
            end
            else if (mode <= 6)
                b = 8'h00;
        end
        else if (op == sjk_pkg::OP_KUTEN_TO_SJIS && mode <= 6)
        begin
            a = 8'($urandom_range(1, 94));
            b = 8'($urandom_range(1, 94));
        end
        send_request(op, a, b, 1'b0, '0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            progress = 1'b0;
            if (start && !busy)
            begin
                pending_codes.insert(pending_codes.size(),
                                     pinned_valid ? pinned_value
                                                  : convert_code(opcode, first_byte,
                                                                 second_byte));
                progress = 1'b1;
            end
            if (done)
            begin
                progress = 1'b1;
                got = '{first_result, second_result, is_regular, is_nonstandard};
                if (pending_codes.size() == 0)
                    note_mismatch("unexpected result", '0, got);
                else
                begin
                    want = pending_codes.pop_front();
                    if (got.res_first !== want.res_first ||
                        got.res_second !== want.res_second ||
                        got.regular !== want.regular ||
                        got.nonstd !== want.nonstd)
                        note_mismatch("result mismatch", want, got);
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("sjis_kuten_code_converter test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        opcode         = sjk_pkg::OP_SJIS_TO_KUTEN;
        first_byte     = 8'h00;
        second_byte    = 8'h00;
        pinned_valid   = 1'b0;
        pinned_value   = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        burst_left     = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].arg_first,
                         directed_rows[i].arg_second, directed_rows[i].pinned,
                         directed_rows[i].value);
        drain_results();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == RANDOM_REQUESTS / 2)
                drain_results();
            send_random_request();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_codes.size() == 0)
            $display("sjis_kuten_code_converter test passed");
        else
            $display("sjis_kuten_code_converter test failed");
        $finish;
    end
endmodule
